// ===== src/smax_pkg.sv =====
// Shared types and constants for the softmax classifier output block.
package smax_pkg;

   localparam int LOGIT_W = 16;
   localparam int PROB_W  = 16;
   localparam int CLASS_W = 6;
   localparam int ROM_AW  = 12;
   localparam int ROM_DEPTH = 1 << ROM_AW;

   localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(ROM_DEPTH - 1);
   localparam logic [PROB_W-1:0] EXP_ONE  = 16'hFFFF;
   localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = {1'b1, {(LOGIT_W-1){1'b0}}};

   // exp(-1/256) in Q0.60 from the first fifteen terms of its series,
   // each term truncated as it is formed.
   localparam logic [63:0] Q60_ONE = 64'd1 << 60;
   localparam logic [63:0] TERM_1  = Q60_ONE / 64'd256;
   localparam logic [63:0] TERM_2  = TERM_1 / 64'd512;
   localparam logic [63:0] TERM_3  = TERM_2 / 64'd768;
   localparam logic [63:0] TERM_4  = TERM_3 / 64'd1024;
   localparam logic [63:0] TERM_5  = TERM_4 / 64'd1280;
   localparam logic [63:0] TERM_6  = TERM_5 / 64'd1536;
   localparam logic [63:0] TERM_7  = TERM_6 / 64'd1792;
   localparam logic [63:0] TERM_8  = TERM_7 / 64'd2048;
   localparam logic [63:0] TERM_9  = TERM_8 / 64'd2304;
   localparam logic [63:0] TERM_10 = TERM_9 / 64'd2560;
   localparam logic [63:0] TERM_11 = TERM_10 / 64'd2816;
   localparam logic [63:0] TERM_12 = TERM_11 / 64'd3072;
   localparam logic [63:0] TERM_13 = TERM_12 / 64'd3328;
   localparam logic [63:0] TERM_14 = TERM_13 / 64'd3584;
   localparam logic [63:0] EXP_STEP = Q60_ONE - TERM_1 + TERM_2 - TERM_3 + TERM_4
                                    - TERM_5 + TERM_6 - TERM_7 + TERM_8 - TERM_9
                                    + TERM_10 - TERM_11 + TERM_12 - TERM_13 + TERM_14;

   // Half of one unit at the Q60 point, for round-half-up scaling.
   localparam logic [79:0] ROUND_HALF = 80'd1 << 59;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic                      last_logit;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0]  probability;
      logic [CLASS_W-1:0] class_index;
      logic [CLASS_W-1:0] best_class;
      logic               last_result;
   } rsp_type;

endpackage

// ===== src/softmax_with_argmax_core.sv =====
// Softmax classifier output with argmax: logit store, exponent table, divider and sequencer.

// Logits arrive one word per cycle as signed Q8.8 and are stored while the running maximum
// is kept; the word flagged last closes the vector, and words beyond MAX_CLASSES are dropped
// although their last flag still closes it. The block then stops taking words: an exponent
// pass walks each class through a store read, a table read and an accumulate, and a normalising
// pass walks each class through a restoring divider that resolves one quotient bit per cycle,
// while the result side may stall it. Results leave in class order as unsigned Q0.16, and the
// last one carries the first class of greatest probability. Once the last result sits in the
// output register the next vector may load. After reset the exponent table is built by a
// shared 32 by 32 multiplier; no word is taken until it is done.
module softmax_with_argmax_core #(
   parameter int MAX_CLASSES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smax_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smax_pkg::rsp_type rsp_data
);
   import smax_pkg::*;

   localparam int IDX_W = $clog2(MAX_CLASSES);
   localparam int CNT_W = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W = PROB_W + IDX_W;

   localparam logic [3:0] ST_FILL_INIT = 4'd0;
   localparam logic [3:0] ST_FILL_MUL  = 4'd1;
   localparam logic [3:0] ST_FILL_WR   = 4'd2;
   localparam logic [3:0] ST_LOAD      = 4'd3;
   localparam logic [3:0] ST_EXP_RD    = 4'd4;
   localparam logic [3:0] ST_EXP_ROM   = 4'd5;
   localparam logic [3:0] ST_EXP_ACC   = 4'd6;
   localparam logic [3:0] ST_DIV_RD    = 4'd7;
   localparam logic [3:0] ST_DIV_INIT  = 4'd8;
   localparam logic [3:0] ST_DIV_STEP  = 4'd9;
   localparam logic [3:0] ST_DIV_PUT   = 4'd10;

   localparam logic [3:0] MUL_LAST = 4'd4;
   localparam logic [3:0] DIV_LAST = 4'd15;

   // Control state
   logic [3:0]                state_ff, state_in;
   logic [3:0]                seq_cnt_ff, seq_cnt_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic signed [LOGIT_W-1:0] max_ff, max_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [ROM_AW-1:0]         k_ff, k_in;
   logic [63:0]               v_ff, v_in;
   logic [127:0]              acc_ff, acc_in;
   logic [127:0]              prod_ff, prod_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      exp_zero_ff, exp_zero_in;
   logic [SUM_W-1:0]          rem_ff, rem_in;
   logic [PROB_W-1:0]         quo_ff, quo_in;
   logic [PROB_W-1:0]         best_p_ff, best_p_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   rsp_type                   rsp_ff, rsp_in;

   // Memories and their read registers
   logic [PROB_W-1:0]         exp_rom_ff [ROM_DEPTH];
   logic [LOGIT_W-1:0]        logit_store_ff [MAX_CLASSES];
   logic [PROB_W-1:0]         exp_store_ff [MAX_CLASSES];
   logic [PROB_W-1:0]         rom_rd_ff;
   logic [LOGIT_W-1:0]        logit_rd_ff;
   logic [PROB_W-1:0]         exp_rd_ff;

   logic                      rom_we;
   logic [ROM_AW-1:0]         rom_wa;
   logic [PROB_W-1:0]         rom_wd;
   logic                      store_we;
   logic                      exp_we;
   logic [PROB_W-1:0]         exp_wd;

   // Combinational helpers
   logic [31:0]               mul_a, mul_b;
   logic [63:0]               mul_p;
   logic [6:0]                mul_sh;
   logic [63:0]               v_new;
   logic [79:0]               scaled;
   logic [16:0]               neg_d;
   logic [31:0]               num;
   logic [SUM_W:0]            trial;
   logic [SUM_W:0]            diff;
   logic                      trial_ge;
   logic                      req_fire;
   logic [CNT_W-1:0]          cnt_next;
   logic signed [LOGIT_W-1:0] max_next;
   logic                      is_last;
   logic                      put_fire;
   logic                      best_upd;
   logic [IDX_W-1:0]          best_idx_new;
   logic [IDX_W+CLASS_W-1:0]  idx_wide, best_wide;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Partial products of v times the step constant, low and high halves.
   assign mul_a  = seq_cnt_ff[1] ? v_ff[63:32] : v_ff[31:0];
   assign mul_b  = seq_cnt_ff[0] ? EXP_STEP[63:32] : EXP_STEP[31:0];
   assign mul_p  = 64'(mul_a) * 64'(mul_b);
   assign mul_sh = {({1'b0, seq_cnt_ff[1]} + {1'b0, seq_cnt_ff[0]}), 5'd0};

   // v * 65535 taken as (v << 16) - v, then rounded at the Q60 point.
   assign v_new  = acc_ff[123:60];
   assign scaled = ({v_new, 16'd0} - {16'd0, v_new}) + ROUND_HALF;

   assign neg_d = {max_ff[LOGIT_W-1], max_ff} - {logit_rd_ff[LOGIT_W-1], logit_rd_ff};

   assign num      = {exp_rd_ff, 16'd0} - {16'd0, exp_rd_ff};
   assign trial    = {rem_ff, quo_ff[PROB_W-1]};
   assign diff     = trial - {1'b0, sum_ff};
   assign trial_ge = (trial >= {1'b0, sum_ff});

   assign store_we = req_fire && (cnt_ff < CNT_W'(MAX_CLASSES));
   assign cnt_next = store_we ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign max_next = (store_we && (req_data.logit > max_ff)) ? req_data.logit : max_ff;

   assign is_last      = (CNT_W'(idx_ff) == n_ff - CNT_W'(1));
   assign put_fire     = (state_ff == ST_DIV_PUT) && (!rsp_valid_ff || rsp_ready);
   assign best_upd     = (idx_ff == '0) || (quo_ff > best_p_ff);
   assign best_idx_new = best_upd ? idx_ff : best_idx_ff;
   assign idx_wide     = {{CLASS_W{1'b0}}, idx_ff};
   assign best_wide    = {{CLASS_W{1'b0}}, best_idx_new};

   assign exp_wd = exp_zero_ff ? '0 : rom_rd_ff;

   always_comb begin
      state_in     = state_ff;
      seq_cnt_in   = seq_cnt_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      k_in         = k_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      exp_zero_in  = exp_zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      best_p_in    = best_p_ff;
      best_idx_in  = best_idx_ff;
      rsp_in       = rsp_ff;
      rom_we       = 1'b0;
      rom_wa       = k_ff;
      rom_wd       = scaled[75:60];
      exp_we       = 1'b0;

      unique case (state_ff)
         ST_FILL_INIT: begin
            rom_we     = 1'b1;
            rom_wa     = '0;
            rom_wd     = EXP_ONE;
            v_in       = Q60_ONE;
            k_in       = ROM_AW'(1);
            acc_in     = '0;
            seq_cnt_in = '0;
            state_in   = ST_FILL_MUL;
         end
         ST_FILL_MUL: begin
            // The product is registered and folded into the sum in the following cycle.
            if (seq_cnt_ff != MUL_LAST) begin
               prod_in = {64'd0, mul_p} << mul_sh;
            end
            if (seq_cnt_ff != '0) begin
               acc_in = acc_ff + prod_ff;
            end
            if (seq_cnt_ff == MUL_LAST) begin
               state_in = ST_FILL_WR;
            end else begin
               seq_cnt_in = seq_cnt_ff + 4'd1;
            end
         end
         ST_FILL_WR: begin
            rom_we     = 1'b1;
            v_in       = v_new;
            acc_in     = '0;
            seq_cnt_in = '0;
            if (k_ff == ROM_LAST) begin
               state_in = ST_LOAD;
            end else begin
               k_in     = k_ff + ROM_AW'(1);
               state_in = ST_FILL_MUL;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_next;
            max_in = max_next;
            if (req_fire && req_data.last_logit) begin
               n_in     = cnt_next;
               cnt_in   = '0;
               idx_in   = '0;
               sum_in   = '0;
               state_in = ST_EXP_RD;
            end
         end
         ST_EXP_RD: begin
            state_in = ST_EXP_ROM;
         end
         ST_EXP_ROM: begin
            exp_zero_in = (neg_d[16:ROM_AW] != '0);
            state_in    = ST_EXP_ACC;
         end
         ST_EXP_ACC: begin
            exp_we = 1'b1;
            sum_in = sum_ff + SUM_W'(exp_wd);
            if (is_last) begin
               idx_in   = '0;
               max_in   = LOGIT_MIN;
               state_in = ST_DIV_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_EXP_RD;
            end
         end
         ST_DIV_RD: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            // The quotient fits in 16 bits, so the upper half seeds the remainder.
            rem_in     = SUM_W'(num[31:16]);
            quo_in     = num[15:0];
            seq_cnt_in = '0;
            state_in   = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            rem_in = trial_ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_in = {quo_ff[PROB_W-2:0], trial_ge};
            if (seq_cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_PUT;
            end else begin
               seq_cnt_in = seq_cnt_ff + 4'd1;
            end
         end
         ST_DIV_PUT: begin
            if (put_fire) begin
               rsp_valid_in       = 1'b1;
               rsp_in.probability = quo_ff;
               rsp_in.class_index = idx_wide[CLASS_W-1:0];
               rsp_in.best_class  = is_last ? best_wide[CLASS_W-1:0] : '0;
               rsp_in.last_result = is_last;
               best_idx_in        = best_idx_new;
               if (best_upd) begin
                  best_p_in = quo_ff;
               end
               if (is_last) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_DIV_RD;
               end
            end
         end
         default: begin
            state_in = ST_FILL_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_INIT;
         seq_cnt_ff   <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         max_ff       <= LOGIT_MIN;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_cnt_ff   <= seq_cnt_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      exp_zero_ff <= exp_zero_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      best_p_ff   <= best_p_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   // Exponent table: filled once after reset, read at the class's distance below the maximum.
   always_ff @(posedge clock) begin
      if (rom_we) begin
         exp_rom_ff[rom_wa] <= rom_wd;
      end
      rom_rd_ff <= exp_rom_ff[neg_d[ROM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         logit_store_ff[cnt_ff[IDX_W-1:0]] <= req_data.logit;
      end
      logit_rd_ff <= logit_store_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_store_ff[idx_ff] <= exp_wd;
      end
      exp_rd_ff <= exp_store_ff[idx_ff];
   end

   // The greatest logit always contributes a full-scale exponent.
   a_sum_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_INIT) |-> (sum_ff >= SUM_W'(EXP_ONE)))
      else $error("exponent sum below full scale at division");

   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_ACC) |=> (sum_ff >= $past(sum_ff)))
      else $error("exponent sum wrapped");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_STEP) |-> (rem_ff < sum_ff))
      else $error("divider remainder not below divisor");

   a_prob_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_PUT) |-> (quo_ff <= exp_rd_ff))
      else $error("probability exceeds its exponent");

endmodule
